// ===== rtl/kcrle_pkg.sv =====
// Shared types for the key colour run-length pixel decoder.
// Holds the input and result transaction structs, the internal result bundle, csr indexes
// and command bits. No dependencies.
package kcrle_pkg;

   localparam int unsigned COLOUR_BITS = 8;
   localparam int unsigned REPEAT_BITS = 14;
   localparam int unsigned TOTAL_BITS  = 24;
   localparam int unsigned CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_RED     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_GREEN   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_BLUE    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXEL_TOTAL = 2'd3;

   localparam logic [7:0] CMD_KEY_BIT    = 8'h80;
   localparam logic [7:0] CMD_LONG_BIT   = 8'h40;
   localparam logic [7:0] CMD_COUNT_MASK = 8'h3F;
   localparam logic [7:0] LIT_COUNT_MASK = 8'h7F;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       image_start;
   } req_type;

   typedef struct packed {
      logic [COLOUR_BITS-1:0] red;
      logic [COLOUR_BITS-1:0] green;
      logic [COLOUR_BITS-1:0] blue;
      logic [REPEAT_BITS-1:0] repeat_count;
      logic                   image_done;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// ===== rtl/key_color_rle_pixel_decoder.sv =====
// Key colour run-length pixel decoder: top level.
// Takes one payload byte per transaction on req_ and returns pixels or key runs on rsp_.
// Depends on kcrle_pkg, kcrle_decode and kcrle_skid.
//
// Usage:
//   csr_ writes key_red, key_green, key_blue (indexes 0..2) and pixel_total (index 3);
//   write them while no transaction is in flight.
//   req_ carries one payload byte per transaction; image_start marks the first command
//   byte of a new image and clears the decode state and pixel count.
//   rsp_ carries a colour, a repeat count (1 for literal pixels) and image_done on the
//   result that fills the image; bytes after that are dropped until image_start.
// Throughput: one byte per cycle while req_stall is low; the decode state is updated in the cycle of acceptance.
// Output: each result is registered in the result register, or in the skid stage if that is stalled.
// Stall: the result register plus one skid stage hold results while rsp_stall is high;
//   req_stall rises only once both are full.
// Reset: synchronous; clears all but the result data registers, pixel_total becomes 0, so every byte is
//   dropped until pixel_total is written.
module key_color_rle_pixel_decoder import kcrle_pkg::*; #(
   parameter int unsigned PIXEL_COUNT_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [TOTAL_BITS-1:0]     csr_wdata
);

   result_type result;
   logic       accept;

   assign accept = req_valid & ~req_stall;

   kcrle_decode #(
      .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   kcrle_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/kcrle_decode.sv =====
// Command decoder, pixel counter and configuration registers of the decoder.
// Updates the decode state for every accepted byte and forms at most one result.
// Depends on kcrle_pkg.
module kcrle_decode import kcrle_pkg::*; #(
   parameter int unsigned PIXEL_COUNT_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  req_type                   req_data,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [TOTAL_BITS-1:0]     csr_wdata,
   output result_type                result
);

   localparam int unsigned CW = (PIXEL_COUNT_BITS > REPEAT_BITS) ? PIXEL_COUNT_BITS
                                                                  : REPEAT_BITS;

   typedef enum logic [3:0] {
      MODE_CMD      = 4'b0001,
      MODE_LONG_LIT = 4'b0010,
      MODE_LONG_KEY = 4'b0100,
      MODE_LIT      = 4'b1000
   } mode_type;

   logic [7:0]                  key_red_ff, key_green_ff, key_blue_ff;
   logic [TOTAL_BITS-1:0]       pixel_total_ff;

   mode_type                    mode_ff, mode_in, eff_mode;
   logic [5:0]                  high_ff, high_in, eff_high;
   logic [REPEAT_BITS-1:0]      lit_left_ff, lit_left_in, eff_lit_left, lit_dec;
   logic [1:0]                  bip_ff, bip_in, eff_bip;
   logic [7:0]                  held_red_ff, held_red_in, eff_held_red;
   logic [7:0]                  held_green_ff, held_green_in, eff_held_green;
   logic [PIXEL_COUNT_BITS-1:0] emitted_ff, emitted_in, eff_emitted;

   logic [PIXEL_COUNT_BITS-1:0] total;
   logic [PIXEL_COUNT_BITS-1:0] left;
   logic [PIXEL_COUNT_BITS-1:0] emitted_sum;
   logic [REPEAT_BITS-1:0]      rep;
   logic                        done_before;
   logic [7:0]                  byte_v;
   logic [REPEAT_BITS-1:0]      long_n;

   logic                        emit_req;
   logic [7:0]                  emit_r, emit_g, emit_b;
   logic [REPEAT_BITS-1:0]      emit_n;

   assign total   = PIXEL_COUNT_BITS'(pixel_total_ff);
   assign byte_v  = req_data.data_byte;

   always_comb begin
      if (req_data.image_start) begin
         eff_mode       = MODE_CMD;
         eff_high       = '0;
         eff_lit_left   = '0;
         eff_bip        = '0;
         eff_held_red   = '0;
         eff_held_green = '0;
         eff_emitted    = '0;
      end else begin
         eff_mode       = mode_ff;
         eff_high       = high_ff;
         eff_lit_left   = lit_left_ff;
         eff_bip        = bip_ff;
         eff_held_red   = held_red_ff;
         eff_held_green = held_green_ff;
         eff_emitted    = emitted_ff;
      end
   end

   assign done_before = (eff_emitted >= total);
   assign long_n      = {eff_high, byte_v};
   assign lit_dec     = eff_lit_left - REPEAT_BITS'(1);

   always_comb begin
      mode_in       = eff_mode;
      high_in       = eff_high;
      lit_left_in   = eff_lit_left;
      bip_in        = eff_bip;
      held_red_in   = eff_held_red;
      held_green_in = eff_held_green;
      emit_req      = 1'b0;
      emit_r        = key_red_ff;
      emit_g        = key_green_ff;
      emit_b        = key_blue_ff;
      emit_n        = long_n;
      if (!done_before) begin
         case (eff_mode)
            MODE_LONG_KEY: begin
               mode_in  = MODE_CMD;
               emit_n   = long_n;
               emit_req = (long_n != '0);
            end
            MODE_LONG_LIT: begin
               if (long_n == '0) begin
                  mode_in = MODE_CMD;
               end else begin
                  lit_left_in = long_n;
                  bip_in      = 2'd0;
                  mode_in     = MODE_LIT;
               end
            end
            MODE_LIT: begin
               case (eff_bip)
                  2'd0: begin
                     held_red_in = byte_v;
                     bip_in      = 2'd1;
                  end
                  2'd1: begin
                     held_green_in = byte_v;
                     bip_in        = 2'd2;
                  end
                  default: begin
                     bip_in      = 2'd0;
                     lit_left_in = lit_dec;
                     if (lit_dec == '0) begin
                        mode_in = MODE_CMD;
                     end
                     emit_req = 1'b1;
                     emit_r   = eff_held_red;
                     emit_g   = eff_held_green;
                     emit_b   = byte_v;
                     emit_n   = REPEAT_BITS'(1);
                  end
               endcase
            end
            default: begin
               mode_in = MODE_CMD;
               if ((byte_v & CMD_KEY_BIT) != '0) begin
                  if ((byte_v & CMD_LONG_BIT) != '0) begin
                     high_in = 6'(byte_v & CMD_COUNT_MASK);
                     mode_in = MODE_LONG_KEY;
                  end else begin
                     emit_n   = REPEAT_BITS'(byte_v & CMD_COUNT_MASK);
                     emit_req = ((byte_v & CMD_COUNT_MASK) != '0);
                  end
               end else if ((byte_v & CMD_LONG_BIT) != '0) begin
                  high_in = 6'(byte_v & CMD_COUNT_MASK);
                  mode_in = MODE_LONG_LIT;
               end else if ((byte_v & LIT_COUNT_MASK) == '0) begin
                  mode_in = MODE_CMD;
               end else begin
                  lit_left_in = REPEAT_BITS'(byte_v & LIT_COUNT_MASK);
                  bip_in      = 2'd0;
                  mode_in     = MODE_LIT;
               end
            end
         endcase
      end
   end

   // clip at the pixels still missing
   always_comb begin
      left        = total - eff_emitted;
      rep         = (CW'(emit_n) < CW'(left)) ? emit_n : REPEAT_BITS'(CW'(left));
      emitted_sum = eff_emitted + PIXEL_COUNT_BITS'(rep);
      emitted_in  = emit_req ? emitted_sum : eff_emitted;
   end

   always_comb begin
      result.valid             = accept & emit_req;
      result.data.red          = emit_r;
      result.data.green        = emit_g;
      result.data.blue         = emit_b;
      result.data.repeat_count = rep;
      result.data.image_done   = (emitted_sum >= total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_red_ff     <= '0;
         key_green_ff   <= '0;
         key_blue_ff    <= '0;
         pixel_total_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_KEY_RED:     key_red_ff     <= csr_wdata[7:0];
            CSR_KEY_GREEN:   key_green_ff   <= csr_wdata[7:0];
            CSR_KEY_BLUE:    key_blue_ff    <= csr_wdata[7:0];
            CSR_PIXEL_TOTAL: pixel_total_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CMD;
         high_ff       <= '0;
         lit_left_ff   <= '0;
         bip_ff        <= '0;
         held_red_ff   <= '0;
         held_green_ff <= '0;
         emitted_ff    <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         high_ff       <= high_in;
         lit_left_ff   <= lit_left_in;
         bip_ff        <= bip_in;
         held_red_ff   <= held_red_in;
         held_green_ff <= held_green_in;
         emitted_ff    <= emitted_in;
      end
   end

   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (result.data.repeat_count != '0))
      else $error("result with zero repeat count");

   a_lit_has_pixels: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_LIT) |-> (lit_left_ff != '0) && (bip_ff != 2'd3))
      else $error("literal mode with no pixels left or bad byte position");

   a_done_reaches_total: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.data.image_done) |=> (emitted_ff >= $past(total)))
      else $error("image_done flagged below pixel total");

endmodule

// ===== rtl/kcrle_skid.sv =====
// Result register with a skid stage for the decoder's result channel.
// Holds a result while the receiver stalls and stalls the input once the skid stage is full.
// Depends on kcrle_pkg.
module kcrle_skid import kcrle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take;

   assign take = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result.valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = result.data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result.data;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full with empty result register");

   a_no_result_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !result.valid)
      else $error("result arrived while skid stage full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid stage failed to advance");

endmodule
